// File: rtl/pcc_pkg.sv
// Shared constants, codes and job control type for the polygon convexity checker.
package pcc_pkg;

  // Default coordinate width and fixed widths
  localparam int COORD_BITS  = 16;
  localparam int TOL_BITS    = 33;
  localparam int QUEUE_DEPTH = 4;

  // Points carried per job: older, newer, current, first, second
  localparam int JOB_POINTS  = 5;
  localparam int NUM_LANES   = 3;

  // Turn codes
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // Polygon class codes
  localparam logic [1:0] CLASS_BORDER     = 2'd0;
  localparam logic [1:0] CLASS_CONVEX     = 2'd1;
  localparam logic [1:0] CLASS_NOT_CONVEX = 2'd2;

  // Control part of one job handed from front to back
  typedef struct packed {
    logic [NUM_LANES-1:0] tri_valid;   // which of the three triples are real
    logic                 last;        // vertex closes the ring
    logic                 short_ring;  // fewer than three vertices in the ring
  } job_ctrl_t;

endpackage

// File: rtl/pcc_front.sv
// Front end: accepts vertices, tracks ring state and builds cross-product jobs.
module pcc_front #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [COORD_BITS-1:0]                   point_x_i,
  input  logic [COORD_BITS-1:0]                   point_y_i,
  input  logic                                    last_point_i,
  input  logic                                    q_full_i,
  output logic                                    push_o,
  output pcc_pkg::job_ctrl_t                      job_ctrl_o,
  output logic [2*pcc_pkg::JOB_POINTS*COORD_BITS-1:0] job_pts_o
);

  logic [COORD_BITS-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic [COORD_BITS-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic [1:0]            cnt_q, cnt_d;
  logic                  has_tri;

  // a beat is taken whenever the queue has room
  assign push_o     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // two earlier vertices present: the current vertex closes a triple
  assign has_tri = cnt_q[1];

  assign job_ctrl_o.tri_valid = {last_point_i && has_tri, last_point_i && has_tri, has_tri};
  assign job_ctrl_o.last       = last_point_i;
  assign job_ctrl_o.short_ring = !has_tri;

  // consecutive points form the triples (0,1,2), (1,2,3), (2,3,4)
  assign job_pts_o = {second_y_q, second_x_q, first_y_q, first_x_q,
                      point_y_i, point_x_i, newer_y_q, newer_x_q,
                      older_y_q, older_x_q};

  // vertex count saturates at three, cleared by the closing vertex
  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (last_point_i) begin
        cnt_d = 2'd0;
      end else if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // vertex history
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      if (cnt_q == 2'd0) begin
        first_x_q <= point_x_i;
        first_y_q <= point_y_i;
      end
      if (cnt_q == 2'd1) begin
        second_x_q <= point_x_i;
        second_y_q <= point_y_i;
      end
      older_x_q <= newer_x_q;
      older_y_q <= newer_y_q;
      newer_x_q <= point_x_i;
      newer_y_q <= point_y_i;
    end
  end

  // closing vertex restarts the ring
  a_ring_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && last_point_i |=> cnt_q == 2'd0)
    else $error("ring count not cleared after closing vertex");

endmodule

// File: rtl/pcc_queue.sv
// Short FIFO of jobs between the front end and the cross-product back end.
module pcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o     = cnt_q == CntBits'(DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(DEPTH))
    else $error("queue fill level beyond depth");

endmodule

// File: rtl/pcc_cross.sv
// One cross-product lane: two multipliers, then difference, magnitude and tolerance test.
module pcc_cross #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pcc_pkg::TOL_BITS-1:0] tol_i,
  input  logic [COORD_BITS-1:0]        ax_i,
  input  logic [COORD_BITS-1:0]        ay_i,
  input  logic [COORD_BITS-1:0]        bx_i,
  input  logic [COORD_BITS-1:0]        by_i,
  input  logic [COORD_BITS-1:0]        cx_i,
  input  logic [COORD_BITS-1:0]        cy_i,
  output logic [1:0]                   turn_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int ZW = PW + 1;
  localparam int CW = (ZW > pcc_pkg::TOL_BITS) ? ZW : pcc_pkg::TOL_BITS;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [PW-1:0] p_d, q_d, p_q, q_q;
  logic signed [ZW-1:0] z;
  logic        [ZW-1:0] z_mag;
  logic                 z_neg;
  logic        [1:0]    turn_d, turn_q;

  // edge vectors b-a and c-b, sign extended by one bit
  assign d1x = $signed({bx_i[COORD_BITS-1], bx_i}) - $signed({ax_i[COORD_BITS-1], ax_i});
  assign d1y = $signed({by_i[COORD_BITS-1], by_i}) - $signed({ay_i[COORD_BITS-1], ay_i});
  assign d2x = $signed({cx_i[COORD_BITS-1], cx_i}) - $signed({bx_i[COORD_BITS-1], bx_i});
  assign d2y = $signed({cy_i[COORD_BITS-1], cy_i}) - $signed({by_i[COORD_BITS-1], by_i});

  assign p_d = d1x * d2y;
  assign q_d = d1y * d2x;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end

  // z term, magnitude and tolerance compare
  assign z     = $signed({p_q[PW-1], p_q}) - $signed({q_q[PW-1], q_q});
  assign z_neg = z[ZW-1];
  assign z_mag = z_neg ? ZW'(-z) : ZW'(z);

  always_comb begin
    if (CW'(z_mag) <= CW'(tol_i)) begin
      turn_d = pcc_pkg::TURN_NONE;
    end else if (z_neg) begin
      turn_d = pcc_pkg::TURN_RIGHT;
    end else begin
      turn_d = pcc_pkg::TURN_LEFT;
    end
  end

  // stage 2: turn code
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      turn_q <= turn_d;
    end
  end

  assign turn_o = turn_q;

endmodule

// File: rtl/pcc_back.sv
// Back end: three cross-product lanes, turn bookkeeping and the result register.
module pcc_back #(
  parameter int COORD_BITS = pcc_pkg::COORD_BITS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        tol_we_i,
  input  logic [pcc_pkg::TOL_BITS-1:0]                tol_i,
  input  logic                                        q_valid_i,
  input  pcc_pkg::job_ctrl_t                          q_ctrl_i,
  input  logic [2*pcc_pkg::JOB_POINTS*COORD_BITS-1:0] q_pts_i,
  output logic                                        q_pop_o,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic [1:0]                                  polygon_class_o,
  output logic [1:0]                                  turn_sense_o
);

  localparam int CB = COORD_BITS;
  localparam int NL = pcc_pkg::NUM_LANES;

  logic [pcc_pkg::TOL_BITS-1:0] tol_q;
  logic                         adv;
  logic                         s1_valid_q, s2_valid_q;
  pcc_pkg::job_ctrl_t           s1_ctrl_q, s2_ctrl_q;
  logic [1:0]                   turn_w [NL];
  logic [1:0]                   first_turn_q, first_turn_d;
  logic                         rev_q, rev_d;
  logic [1:0]                   ft_acc;
  logic                         rev_acc;
  logic                         out_valid_q;
  logic [1:0]                   class_q, class_d, sense_q, sense_d;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (tol_we_i) begin
      tol_q <= tol_i;
    end
  end

  // whole back pipeline moves unless a result is held by the sink
  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  // lane k evaluates the triple of points k, k+1, k+2
  for (genvar k = 0; k < NL; k++) begin : g_lane
    pcc_cross #(
      .COORD_BITS(COORD_BITS)
    ) u_cross (
      .clk_i  (clk_i),
      .en_i   (adv),
      .tol_i  (tol_q),
      .ax_i   (q_pts_i[(2*k)*CB     +: CB]),
      .ay_i   (q_pts_i[(2*k+1)*CB   +: CB]),
      .bx_i   (q_pts_i[(2*k+2)*CB   +: CB]),
      .by_i   (q_pts_i[(2*k+3)*CB   +: CB]),
      .cx_i   (q_pts_i[(2*k+4)*CB   +: CB]),
      .cy_i   (q_pts_i[(2*k+5)*CB   +: CB]),
      .turn_o (turn_w[k])
    );
  end

  // control follows the lanes through their two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctrl_q <= q_ctrl_i;
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  // fold the turns of this beat in ring order
  always_comb begin
    ft_acc  = first_turn_q;
    rev_acc = rev_q;
    for (int i = 0; i < NL; i++) begin
      if (s2_ctrl_q.tri_valid[i] && turn_w[i] != pcc_pkg::TURN_NONE) begin
        if (ft_acc == pcc_pkg::TURN_NONE) begin
          ft_acc = turn_w[i];
        end else if (turn_w[i] != ft_acc) begin
          rev_acc = 1'b1;
        end
      end
    end
  end

  // classify on the closing vertex and restart the ring
  always_comb begin
    first_turn_d = first_turn_q;
    rev_d        = rev_q;
    if (s2_ctrl_q.short_ring || ft_acc == pcc_pkg::TURN_NONE) begin
      class_d = pcc_pkg::CLASS_BORDER;
    end else if (rev_acc) begin
      class_d = pcc_pkg::CLASS_NOT_CONVEX;
    end else begin
      class_d = pcc_pkg::CLASS_CONVEX;
    end
    sense_d = s2_ctrl_q.short_ring ? pcc_pkg::TURN_NONE : ft_acc;
    if (adv && s2_valid_q) begin
      if (s2_ctrl_q.last) begin
        first_turn_d = pcc_pkg::TURN_NONE;
        rev_d        = 1'b0;
      end else begin
        first_turn_d = ft_acc;
        rev_d        = rev_acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_turn_q <= pcc_pkg::TURN_NONE;
      rev_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      first_turn_q <= first_turn_d;
      rev_q        <= rev_d;
      if (adv) begin
        out_valid_q <= s2_valid_q && s2_ctrl_q.last;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_ctrl_q.last) begin
      class_q <= class_d;
      sense_q <= sense_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign polygon_class_o = class_q;
  assign turn_sense_o    = sense_q;

  a_rev_needs_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev_q |-> first_turn_q != pcc_pkg::TURN_NONE)
    else $error("reversal flagged without a first turn");

  a_class_vs_sense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((class_q == pcc_pkg::CLASS_BORDER) == (sense_q == pcc_pkg::TURN_NONE)))
    else $error("polygon class disagrees with turn sense");

endmodule

// File: rtl/polygon_convexity_check_core.sv
// Polygon convexity checker top level: front end, job queue and cross-product back end.
// Vertices stream in one beat per cycle unless stalled; the beat flagged last_point closes
// the ring and yields one result (class and first turn sense), other beats yield none.
// Sustained rate is one vertex per cycle while no result is stalled, set by three
// cross-product lanes of two multipliers each, which cover the ordinary triple and both
// wraparound triples of the closing vertex in the same beat. A vertex is written to a
// QUEUE_DEPTH-entry queue, then passes two lane stages, and then the result register
// loads class and turn sense for its closing vertex.
// Input is stalled only when the queue is full; the back end holds when a result is stalled.
// zero_tolerance may be written only while no ring is in flight.
module polygon_convexity_check_core #(
  parameter int COORD_BITS  = pcc_pkg::COORD_BITS,
  parameter int QUEUE_DEPTH = pcc_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         zero_tolerance_we_i,
  input  logic [pcc_pkg::TOL_BITS-1:0] zero_tolerance_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   polygon_class_o,
  output logic [1:0]                   turn_sense_o
);

  localparam int PtsBits = 2 * pcc_pkg::JOB_POINTS * COORD_BITS;
  localparam int JobBits = $bits(pcc_pkg::job_ctrl_t) + PtsBits;

  logic               push, q_full, q_valid, q_pop;
  pcc_pkg::job_ctrl_t job_ctrl, q_ctrl;
  logic [PtsBits-1:0] job_pts, q_pts;
  logic [JobBits-1:0] q_data;

  pcc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_ctrl_o   (job_ctrl),
    .job_pts_o    (job_pts)
  );

  pcc_queue #(
    .WIDTH(JobBits),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({job_ctrl, job_pts}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  assign q_ctrl = q_data[JobBits-1:PtsBits];
  assign q_pts  = q_data[PtsBits-1:0];

  pcc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tol_we_i        (zero_tolerance_we_i),
    .tol_i           (zero_tolerance_i),
    .q_valid_i       (q_valid),
    .q_ctrl_i        (q_ctrl),
    .q_pts_i         (q_pts),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .polygon_class_o (polygon_class_o),
    .turn_sense_o    (turn_sense_o)
  );

endmodule
